/* hw/rtl/mqd_pkg.sv */
`default_nettype none

package mqd_pkg;

	// defaults for the top-level parameters
	localparam int NUM_QUEUES_DEF   = 4;
	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int HANDLE_WIDTH_DEF = 32;

	// fixed field and register widths
	localparam int PROTO_W    = 3;
	localparam int MASK_W     = 4;
	localparam int LIMIT_W    = 5;
	localparam int NUM_LIMITS = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE_MASK = 3'd0,
		REG_LIMIT_Q0    = 3'd1,
		REG_LIMIT_Q1    = 3'd2,
		REG_LIMIT_Q2    = 3'd3,
		REG_LIMIT_Q3    = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DRAIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;    // latch the incoming request
		logic append;    // store handle at tail, bump occupancy
		logic emit_ack;  // load accept/reject result
		logic issue;     // read at head, drop occupancy
		logic deliver;   // load drained handle result
		logic last;      // the delivered handle is the final one
	} mqd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ok;
		logic kind;
		logic slot_free;
		logic occ_zero;
		logic occ_one;
	} mqd_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/mqd_if.sv */
`default_nettype none

interface mqd_req_if #(
	parameter int HANDLE_WIDTH = 32
);
	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic [2:0]              proto;
	logic [HANDLE_WIDTH-1:0] item_handle;

	modport source (output valid, kind, proto, item_handle, input ready);
	modport sink   (input valid, kind, proto, item_handle, output ready);
endinterface

interface mqd_res_if #(
	parameter int HANDLE_WIDTH = 32
);
	logic                    valid;
	logic                    ready;
	logic                    status;
	logic                    delivered;
	logic [HANDLE_WIDTH-1:0] out_handle;
	logic [2:0]              out_proto;
	logic                    last;

	modport source (output valid, status, delivered, out_handle, out_proto, last, input ready);
	modport sink   (input valid, status, delivered, out_handle, out_proto, last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mqd_ram.sv */
`default_nettype none

module mqd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/mqd_ctrl.sv */
`default_nettype none

module mqd_ctrl
	import mqd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output      logic     req_ready,
	input  wire mqd_sts_t sts,
	output      mqd_cmd_t cmd
);

	state_t state_q, state_d;
	logic   pend_q, pend_d;   // a read is in the ram output register
	logic   last_q, last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			last_q  <= last_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pend_d    = pend_q;
		last_d    = last_q;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.last  = last_q;
		case (state_q)
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
				if (req_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.ok && sts.kind) begin
					cmd.append = 1'b1;
					state_d    = ST_DRAIN;
				end else if (sts.slot_free) begin
					cmd.append   = sts.ok;
					cmd.emit_ack = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_DRAIN: begin
				cmd.issue   = !sts.occ_zero && (!pend_q || sts.slot_free);
				cmd.deliver = pend_q && sts.slot_free;
				pend_d      = cmd.issue || (pend_q && !sts.slot_free);
				if (cmd.issue) begin
					last_d = sts.occ_one;
				end
				if (cmd.deliver && last_q) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				pend_d  = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/mqd_dp.sv */
`default_nettype none

module mqd_dp
	import mqd_pkg::*;
#(
	parameter int NUM_QUEUES   = NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                    req_kind,
	input  wire logic [PROTO_W-1:0]      req_proto,
	input  wire logic [HANDLE_WIDTH-1:0] req_handle,
	input  wire logic                    res_ready,
	output      logic                    res_valid,
	output      logic                    res_status,
	output      logic                    res_delivered,
	output      logic [HANDLE_WIDTH-1:0] res_handle,
	output      logic [PROTO_W-1:0]      res_proto,
	output      logic                    res_last,
	input  wire mqd_cmd_t                cmd,
	output      mqd_sts_t                sts
);

	localparam int QIW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int QSLOTS = 2 ** QIW;
	localparam int PW     = $clog2(QUEUE_DEPTH);
	localparam int OW     = $clog2(QUEUE_DEPTH + 1);
	localparam int CW     = (OW > LIMIT_W) ? OW : LIMIT_W;
	localparam int AW     = $clog2(NUM_QUEUES * QUEUE_DEPTH);

	logic [MASK_W-1:0]       enable_q;
	logic [LIMIT_W-1:0]      limit_q [NUM_LIMITS];
	logic [PW-1:0]           head_q  [QSLOTS];
	logic [PW-1:0]           tail_q  [QSLOTS];
	logic [OW-1:0]           occ_q   [QSLOTS];

	logic                    kind_q;
	logic [PROTO_W-1:0]      proto_q;
	logic [HANDLE_WIDTH-1:0] handle_q;

	logic [QIW-1:0]          qi;
	logic [CW-1:0]           lim_w, eff_w;
	logic                    ok_w;
	logic [AW-1:0]           base_w, waddr_w, raddr_w;
	logic [HANDLE_WIDTH-1:0] rdata_w;
	logic                    slot_free_w, load_w;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
			for (int i = 0; i < NUM_LIMITS; i++) begin
				limit_q[i] <= LIMIT_RESET;
			end
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ENABLE_MASK: enable_q   <= cfg_wdata[MASK_W-1:0];
				REG_LIMIT_Q0:    limit_q[0] <= cfg_wdata[LIMIT_W-1:0];
				REG_LIMIT_Q1:    limit_q[1] <= cfg_wdata[LIMIT_W-1:0];
				REG_LIMIT_Q2:    limit_q[2] <= cfg_wdata[LIMIT_W-1:0];
				REG_LIMIT_Q3:    limit_q[3] <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// latched request
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q   <= req_kind;
			proto_q  <= req_proto;
			handle_q <= req_handle;
		end
	end

	assign qi = proto_q[QIW-1:0];

	// admission check
	always_comb begin
		lim_w = CW'(limit_q[proto_q[1:0]]);
		if (lim_w == '0 || lim_w > CW'(QUEUE_DEPTH)) begin
			eff_w = CW'(QUEUE_DEPTH);
		end else begin
			eff_w = lim_w;
		end
		ok_w = (proto_q < PROTO_W'(NUM_QUEUES)) && (handle_q != '0) &&
			enable_q[proto_q[1:0]] && (CW'(occ_q[qi]) < eff_w);
	end

	// ring pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QSLOTS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				occ_q[i]  <= '0;
			end
		end else if (cmd.append) begin
			tail_q[qi] <= (tail_q[qi] == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q[qi] + 1'b1;
			occ_q[qi]  <= occ_q[qi] + 1'b1;
		end else if (cmd.issue) begin
			head_q[qi] <= (head_q[qi] == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q[qi] + 1'b1;
			occ_q[qi]  <= occ_q[qi] - 1'b1;
		end
	end

	assign base_w  = AW'(AW'(qi) * AW'(QUEUE_DEPTH));
	assign waddr_w = base_w + AW'(tail_q[qi]);
	assign raddr_w = base_w + AW'(head_q[qi]);

	mqd_ram #(
		.WIDTH (HANDLE_WIDTH),
		.DEPTH (NUM_QUEUES * QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.append),
		.waddr (waddr_w),
		.wdata (handle_q),
		.re    (cmd.issue),
		.raddr (raddr_w),
		.rdata (rdata_w)
	);

	// result register
	assign slot_free_w = !res_valid || res_ready;
	assign load_w      = cmd.emit_ack || cmd.deliver;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (load_w) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_w) begin
			res_status    <= (cmd.emit_ack && !ok_w) ? STATUS_REJECT : STATUS_OK;
			res_delivered <= cmd.deliver;
			res_handle    <= cmd.deliver ? rdata_w : '0;
			res_proto     <= proto_q;
			res_last      <= cmd.emit_ack || cmd.last;
		end
	end

	assign sts.ok        = ok_w;
	assign sts.kind      = kind_q;
	assign sts.slot_free = slot_free_w;
	assign sts.occ_zero  = (occ_q[qi] == '0);
	assign sts.occ_one   = (occ_q[qi] == OW'(1));

endmodule

`default_nettype wire

/* hw/rtl/multi_queue_dispatch_engine.sv */
`default_nettype none

// multi-queue dispatch engine: one bounded ring queue of handles per protocol,
// all queues sharing one handle ram of NUM_QUEUES*QUEUE_DEPTH entries. a
// request with kind 0 appends its handle and returns one result (status 0 =
// accepted, 1 = rejected, last set). a request with kind 1 appends the same
// way and, if accepted, drains the whole queue oldest first, one delivered
// result per handle, last set on the final one; a rejected dispatch returns a
// single reject result. a request is rejected when proto is not a queue, the
// handle is zero, the protocol is not enabled or the queue is at its limit
// (limit 0 or above the depth means full depth). one request is worked at a
// time: a queue request is accepted, then checked and stored; a dispatch then
// drains the handle ram (a registered read) at one handle per cycle while the
// result register is free. the result register lets the next request in while
// a result still waits. the user must make config writes only while idle; the
// block leaves it to the user: index 0 enable_mask, 1..4 limit of queue 0..3.

module multi_queue_dispatch_engine
	import mqd_pkg::*;
#(
	parameter int NUM_QUEUES   = NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	mqd_req_if.sink                    req,
	mqd_res_if.source                  res,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	mqd_cmd_t cmd;
	mqd_sts_t sts;
	logic     ready_w;

	assign req.ready = ready_w;

	// sequencer: idle / check and store / drain
	mqd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready_w),
		.sts       (sts),
		.cmd       (cmd)
	);

	// queue state, handle ram and result register
	mqd_dp #(
		.NUM_QUEUES   (NUM_QUEUES),
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.req_kind      (req.kind),
		.req_proto     (req.proto),
		.req_handle    (req.item_handle),
		.res_ready     (res.ready),
		.res_valid     (res.valid),
		.res_status    (res.status),
		.res_delivered (res.delivered),
		.res_handle    (res.out_handle),
		.res_proto     (res.out_proto),
		.res_last      (res.last),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

`default_nettype wire

/* bench/multi_queue_dispatch_engine_tb.sv */
`default_nettype none

module multi_queue_dispatch_engine_tb;
	import mqd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NQ     = NUM_QUEUES_DEF;
	localparam int DEPTH  = QUEUE_DEPTH_DEF;
	localparam int HW     = HANDLE_WIDTH_DEF;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	// request kinds
	localparam logic KIND_QUEUE    = 1'b0;
	localparam logic KIND_DISPATCH = 1'b1;

	// an index past the last register, writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(NUM_LIMITS + 1);

	// cycles to let pass once nothing is outstanding, before the verdict
	localparam int SETTLE_CYCLES = 20;

	// one result as seen on the result channel
	typedef struct packed {
		logic                status;
		logic                delivered;
		logic [HW-1:0]       handle;
		logic [PROTO_W-1:0]  proto;
		logic                last;
	} outcome_t;

	// mirror of the per-protocol rings plus the queue of results still owed
	class dispatch_book;
		logic [HW-1:0]      slots [NQ][DEPTH];
		logic [PTR_W-1:0]   head_pos [NQ];
		logic [PTR_W-1:0]   tail_pos [NQ];
		logic [FILL_W-1:0]  fill [NQ];
		logic [MASK_W-1:0]  enables;
		logic [LIMIT_W-1:0] limits [NUM_LIMITS];
		outcome_t           awaited [$];
		int unsigned        mismatches, requests, rejected, drained, checked;

		function new();
			enables = '0;
			for (int q = 0; q < NQ; q++) begin
				head_pos[q] = '0;
				tail_pos[q] = '0;
				fill[q] = '0;
			end
			for (int i = 0; i < NUM_LIMITS; i++)
				limits[i] = LIMIT_RESET;
			mismatches = 0;
			requests = 0;
			rejected = 0;
			drained = 0;
			checked = 0;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ENABLE_MASK: enables = data[MASK_W-1:0];
				REG_LIMIT_Q0: limits[0] = data;
				REG_LIMIT_Q1: limits[1] = data;
				REG_LIMIT_Q2: limits[2] = data;
				REG_LIMIT_Q3: limits[3] = data;
				default: ;
			endcase
		endfunction

		// a limit of zero or past the ring size means the whole ring
		function int unsigned cap(int unsigned q);
			if (limits[q] == 0 || limits[q] > DEPTH)
				return DEPTH;
			return limits[q];
		endfunction

		function logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
			return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
		endfunction

		function void note_request(logic kind, logic [PROTO_W-1:0] proto, logic [HW-1:0] handle);
			outcome_t    o;
			int unsigned q;
			requests++;
			q = proto;
			o.status = STATUS_REJECT;
			o.delivered = 1'b0;
			o.handle = '0;
			o.proto = proto;
			o.last = 1'b1;
			if (q >= NQ || handle == '0 || !enables[q] || fill[q] >= cap(q)) begin
				rejected++;
				awaited.push_back(o);
				return;
			end
			slots[q][tail_pos[q]] = handle;
			tail_pos[q] = step_ptr(tail_pos[q]);
			fill[q]++;
			o.status = STATUS_OK;
			if (kind == KIND_QUEUE) begin
				awaited.push_back(o);
				return;
			end
			// dispatch: empty the whole ring, oldest handle first
			o.delivered = 1'b1;
			while (fill[q] != 0) begin
				o.handle = slots[q][head_pos[q]];
				head_pos[q] = step_ptr(head_pos[q]);
				fill[q]--;
				o.last = (fill[q] == 0);
				drained++;
				awaited.push_back(o);
			end
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 40)
				$display("MISMATCH @%0t ns: %s", $time, what);
		endtask

		task check_result(outcome_t got);
			outcome_t want;
			string    diff;
			checked++;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result, proto %0d handle %h", got.proto, got.handle));
				return;
			end
			want = awaited.pop_front();
			diff = "";
			if (got.status !== want.status)
				diff = {diff, $sformatf(" status %b/%b", got.status, want.status)};
			if (got.delivered !== want.delivered)
				diff = {diff, $sformatf(" delivered %b/%b", got.delivered, want.delivered)};
			if (got.handle !== want.handle)
				diff = {diff, $sformatf(" handle %h/%h", got.handle, want.handle)};
			if (got.proto !== want.proto)
				diff = {diff, $sformatf(" proto %0d/%0d", got.proto, want.proto)};
			if (got.last !== want.last)
				diff = {diff, $sformatf(" last %b/%b", got.last, want.last)};
			if (diff != "")
				report($sformatf("result %0d (got/expected):%s", checked, diff));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	mqd_req_if #(.HANDLE_WIDTH(HW)) req_ch ();
	mqd_res_if #(.HANDLE_WIDTH(HW)) res_ch ();

	dispatch_book book = new();
	int unsigned  settings_applied = 0;

	multi_queue_dispatch_engine #(
		.NUM_QUEUES   (NQ),
		.QUEUE_DEPTH  (DEPTH),
		.HANDLE_WIDTH (HW)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// any nonzero handle, all bits free to toggle
	function automatic logic [HW-1:0] live_handle();
		logic [HW-1:0] h;
		h = HW'($urandom);
		if (h == '0)
			h = HW'(1);
		return h;
	endfunction

	// present one request at a falling edge, hold it until taken, then idle for the given gap
	// returns at a falling edge; valid stays high when gap is zero
	task automatic send_request(logic kind, logic [PROTO_W-1:0] proto, logic [HW-1:0] handle,
			int unsigned gap);
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.proto <= proto;
		req_ch.item_handle <= handle;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		book.note_request(kind, proto, handle);
		@(negedge clk);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// stop sending and wait until every owed result has been taken
	task automatic await_quiet();
		if (req_ch.valid === 1'b1)
			req_ch.valid <= 1'b0;
		while (book.pending() != 0)
			@(negedge clk);
	endtask

	// register writes go one per cycle, only while the block is idle
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		book.write_register(idx, data);
		@(negedge clk);
	endtask

	task automatic apply_settings(logic [CFG_DATA_W-1:0] mask, logic [LIMIT_W-1:0] l0,
			logic [LIMIT_W-1:0] l1, logic [LIMIT_W-1:0] l2, logic [LIMIT_W-1:0] l3);
		write_register(REG_ENABLE_MASK, mask);
		write_register(REG_LIMIT_Q0, l0);
		write_register(REG_LIMIT_Q1, l1);
		write_register(REG_LIMIT_Q2, l2);
		write_register(REG_LIMIT_Q3, l3);
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// limits spread over the interesting spots: zero, one, exactly the depth, past it
	function automatic logic [LIMIT_W-1:0] pick_limit();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return LIMIT_W'(1);
			2: return LIMIT_RESET;
			3: return LIMIT_W'($urandom_range(DEPTH + 1, (1 << LIMIT_W) - 1));
			default: return LIMIT_W'($urandom_range(2, DEPTH - 1));
		endcase
	endfunction

	task automatic random_settings();
		logic [CFG_DATA_W-1:0] mask;
		// mostly everything enabled so requests get deep; top data bit must be ignored
		mask = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom) : CFG_DATA_W'({MASK_W{1'b1}});
		mask[CFG_DATA_W-1] = $urandom_range(0, 1);
		apply_settings(mask, pick_limit(), pick_limit(), pick_limit(), pick_limit());
	endtask

	// random traffic: mostly bursts of appends to one queue closed by a dispatch,
	// the rest out-of-range protocols, null handles and loose single requests
	task automatic run_phase(int unsigned quota);
		int unsigned   sent, burst, i;
		logic [PROTO_W-1:0] q;
		bit            steady;
		steady = ($urandom_range(0, 3) == 0);
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(0, 99) < 80) begin
				q = PROTO_W'($urandom_range(0, NQ - 1));
				burst = ($urandom_range(0, 9) == 0) ? $urandom_range(8, DEPTH) : $urandom_range(0, 4);
				for (i = 0; i < burst; i++) begin
					send_request(KIND_QUEUE, q, live_handle(), steady ? 0 : pick_gap());
					sent++;
				end
				if ($urandom_range(0, 4) != 0) begin
					send_request(KIND_DISPATCH, q, live_handle(), steady ? 0 : pick_gap());
					sent++;
				end
			end else begin
				case ($urandom_range(0, 2))
					0: send_request(1'($urandom), PROTO_W'($urandom_range(NQ, (1 << PROTO_W) - 1)),
						live_handle(), steady ? 0 : pick_gap());
					1: send_request(1'($urandom), PROTO_W'($urandom), '0, steady ? 0 : pick_gap());
					default: send_request(1'($urandom), PROTO_W'($urandom), HW'($urandom),
						steady ? 0 : pick_gap());
				endcase
				sent++;
			end
			// sometimes hold off until the block has handed back everything
			if ($urandom_range(0, 39) == 0)
				await_quiet();
		end
	endtask

	// result side: ready toggles at falling edges, choppy stretches alternate with steady ones
	initial begin : result_sink
		int unsigned hold, span;
		bit          steady;
		hold = 0;
		span = 0;
		steady = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (span == 0) begin
				steady = ($urandom_range(0, 3) == 0);
				span = $urandom_range(40, 200);
			end
			span--;
			if (hold != 0) begin
				res_ch.ready <= 1'b0;
				hold--;
			end else begin
				res_ch.ready <= 1'b1;
				if (!steady && $urandom_range(0, 3) == 0)
					hold = pick_gap();
			end
		end
	end

	// every result taken at a rising edge goes to the checker
	always @(posedge clk) begin : result_monitor
		outcome_t seen;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			seen.status = res_ch.status;
			seen.delivered = res_ch.delivered;
			seen.handle = res_ch.out_handle;
			seen.proto = res_ch.out_proto;
			seen.last = res_ch.last;
			book.check_result(seen);
		end
	end

	initial begin : stimulus
		int unsigned phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_QUEUE;
		req_ch.proto = '0;
		req_ch.item_handle = '0;
		res_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// out of reset nothing is enabled, so everything bounces
		send_request(KIND_QUEUE, 3'd0, HW'(1), pick_gap());
		send_request(KIND_DISPATCH, 3'd3, '1, pick_gap());
		await_quiet();

		// all enabled; queue 0 limit zero (whole ring), queue 1 limit one,
		// queue 2 exactly the depth, queue 3 past the depth; a write past the last
		// register must change nothing
		apply_settings(CFG_DATA_W'({MASK_W{1'b1}}), '0, LIMIT_W'(1), LIMIT_RESET, '1);
		@(negedge clk);
		write_register(REG_SPARE, '1);
		cfg_we <= 1'b0;

		// protocols past the last queue, null handles
		send_request(KIND_DISPATCH, 3'd4, HW'('h1234), pick_gap());
		send_request(KIND_QUEUE, 3'd7, '1, pick_gap());
		send_request(KIND_QUEUE, 3'd0, '0, pick_gap());
		send_request(KIND_DISPATCH, 3'd1, '0, pick_gap());
		// two appends, then a dispatch that drains all three in order
		send_request(KIND_QUEUE, 3'd0, '1, pick_gap());
		send_request(KIND_QUEUE, 3'd0, {1'b1, {(HW - 1){1'b0}}}, pick_gap());
		send_request(KIND_DISPATCH, 3'd0, HW'(1), pick_gap());
		// limit of one: second append and the dispatch are both turned away
		send_request(KIND_QUEUE, 3'd1, HW'('hA5A5_A5A5), pick_gap());
		send_request(KIND_QUEUE, 3'd1, HW'('h5A5A_5A5A), pick_gap());
		send_request(KIND_DISPATCH, 3'd1, HW'(1), pick_gap());
		for (int i = 0; i < 5; i++)
			send_request(KIND_QUEUE, 3'd2, HW'('h100 + i), pick_gap());
		await_quiet();

		// limit of queue 2 dropped under its fill, queue 1 disabled
		apply_settings(CFG_DATA_W'(4'b1101), LIMIT_W'(1), LIMIT_W'(2), LIMIT_W'(3), '1);
		send_request(KIND_QUEUE, 3'd2, HW'('h200), pick_gap());
		send_request(KIND_DISPATCH, 3'd2, HW'('h201), pick_gap());
		send_request(KIND_QUEUE, 3'd1, HW'('h300), pick_gap());
		await_quiet();

		// open up again and drain what was left behind
		apply_settings(CFG_DATA_W'({MASK_W{1'b1}}), '0, LIMIT_RESET, '0, '1);
		send_request(KIND_DISPATCH, 3'd2, HW'('h202), pick_gap());
		send_request(KIND_DISPATCH, 3'd1, HW'('h301), pick_gap());
		send_request(KIND_DISPATCH, 3'd3, {1'b0, {(HW - 1){1'b1}}}, pick_gap());

		// random phases, each under its own settings; queue contents carry across
		for (phase = 0; phase < 7; phase++) begin
			await_quiet();
			random_settings();
			run_phase(50);
		end

		await_quiet();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (book.pending() != 0)
			book.report($sformatf("%0d results never came", book.pending()));

		$display("run covered %0d requests (%0d turned away) under %0d register settings",
			book.requests, book.rejected, settings_applied);
		$display("%0d results checked, %0d of them drained handles", book.checked, book.drained);
		if (book.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// far beyond the slowest legal run: every dispatch at full drain, every result stalled long
	initial begin : watchdog
		#2_000_000;
		$display("timeout with %0d results outstanding", book.pending());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

/* multi_queue_dispatch_engine.f */
hw/rtl/mqd_pkg.sv
hw/rtl/mqd_if.sv
hw/rtl/mqd_ram.sv
hw/rtl/mqd_ctrl.sv
hw/rtl/mqd_dp.sv
hw/rtl/multi_queue_dispatch_engine.sv
bench/multi_queue_dispatch_engine_tb.sv
